### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Request, status and sizing constants shared by the heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int REQ_W    = 2;
    localparam int SIZE_W   = 19;
    localparam int ADDR_W   = 18;
    localparam int BYTES_W  = 19;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 7;
    localparam int RSIZE_W  = 20;   // rounded request size

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;

    localparam int MIN_SPLIT  = 16;
    localparam int SIZE_ALIGN = 8;

    localparam logic [CFG_W-1:0] PAGES_RESET = 7'd16;

endpackage

### hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Arena allocator: address-ordered linked block table held in one RAM,
// first-fit allocate with split, free with coalescing of neighbours.
// ----------------------------------------------------------------------------
// Sequence: init writes one free block spanning the arena; alloc walks the
//   list (one RAM read a cycle), scans for a spare entry on a split and
//   writes the blocks back; free scans for the address, then merges neighbours.
// Requests are taken one at a time: o_in_stall holds until the result is loaded.
// Reset: control, valid bits, list head and byte counts clear at once; the
//   table RAM is not cleared; an entry's contents count only once it is in use.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_PAGES    = 64,
    parameter int MAX_BLOCKS   = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [SIZE_W-1:0]  i_req_size,
    input  logic [ADDR_W-1:0]  i_free_address,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [ADDR_W-1:0]  o_data_address,
    output logic [BYTES_W-1:0] o_total_bytes,
    output logic [BYTES_W-1:0] o_used_bytes,
    output logic [BYTES_W-1:0] o_free_bytes
);

    // ------------------------------------------------------------------
    // Widths. AW holds any arena offset or length; CW is the working width
    // for sums and compares against the rounded request size.
    // ------------------------------------------------------------------
    localparam int AW = $clog2(MAX_PAGES * PAGE_BYTES + 1);
    localparam int CW = ((AW > RSIZE_W) ? AW : RSIZE_W) + 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);     // link incl. null
    localparam int IW = $clog2(MAX_BLOCKS);         // RAM index

    localparam logic [LW-1:0] NIL   = LW'(MAX_BLOCKS);
    localparam logic [IW-1:0] LASTI = IW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] SPLIT = CW'(MIN_SPLIT);

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] len;
        logic          free;
        logic [LW-1:0] next;
        logic [LW-1:0] prev;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AWALK = 4'd1;   // first-fit walk
    localparam logic [3:0] S_ASCAN = 4'd2;   // find spare entry
    localparam logic [3:0] S_ASPL1 = 4'd3;   // write split remainder
    localparam logic [3:0] S_ASPL2 = 4'd4;   // relink successor
    localparam logic [3:0] S_ACUR  = 4'd5;   // write chosen block
    localparam logic [3:0] S_FSCAN = 4'd6;   // address lookup
    localparam logic [3:0] S_FNXT  = 4'd7;   // look at successor
    localparam logic [3:0] S_FNW   = 4'd8;   // absorb successor
    localparam logic [3:0] S_FNP   = 4'd9;   // relink after absorb
    localparam logic [3:0] S_FPW   = 4'd10;  // absorb into predecessor
    localparam logic [3:0] S_FPN   = 4'd11;  // relink after that
    localparam logic [3:0] S_FHIT  = 4'd12;  // write freed block
    localparam logic [3:0] S_FIN   = 4'd13;  // hand result over

    logic [3:0]            r_state, n_state;
    logic [CFG_W-1:0]      r_pages;
    logic [MAX_BLOCKS-1:0] r_inuse, n_inuse;
    logic [LW-1:0]         r_first, n_first;
    logic [AW-1:0]         r_arena, n_arena;
    logic [AW-1:0]         r_used, n_used;
    logic [LW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_guard, n_guard;
    logic [LW-1:0]         r_aux, n_aux;
    logic [IW-1:0]         r_k, n_k;
    logic [IW-1:0]         r_spare, n_spare;
    logic [CW-1:0]         r_size, n_size;
    logic [ADDR_W-1:0]     r_faddr, n_faddr;
    t_entry                r_ent, n_ent;
    logic [STAT_W-1:0]     r_stat, n_stat;
    logic [ADDR_W-1:0]     r_addr, n_addr;

    logic                  r_ovalid, n_ovalid;
    logic [STAT_W-1:0]     r_ostat;
    logic [ADDR_W-1:0]     r_oaddr;
    logic [BYTES_W-1:0]    r_otot, r_oused, r_ofree;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    t_entry                ram_wdata;
    logic [EW-1:0]         ram_rdata;

    logic                  in_acc;
    logic                  out_load;
    logic [RSIZE_W-1:0]    req_round;
    logic [31:0]           pages_sat;
    logic [AW-1:0]         arena_init;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_FIN) && (!r_ovalid || !i_out_stall);

    // size rounded up to the allocation grain
    assign req_round = (RSIZE_W'(i_req_size) + RSIZE_W'(SIZE_ALIGN - 1))
                     & ~RSIZE_W'(SIZE_ALIGN - 1);

    // page count clamped into [1, MAX_PAGES]
    always_comb begin
        if (r_pages == '0) begin
            pages_sat = 32'd1;
        end else if (32'(r_pages) > 32'(MAX_PAGES)) begin
            pages_sat = 32'(MAX_PAGES);
        end else begin
            pages_sat = 32'(r_pages);
        end
    end
    assign arena_init = AW'(pages_sat * 32'(PAGE_BYTES));

    // ------------------------------------------------------------------
    // Sequencer. Each RAM read is issued in the state before the one that
    // consumes it; a read that is consumed never shares an address with a write.
    // ------------------------------------------------------------------
    always_comb begin
        t_entry        e;
        logic [LW-1:0] g;
        e         = t_entry'(ram_rdata);
        g         = r_guard + LW'(1);
        n_state   = r_state;
        n_inuse   = r_inuse;
        n_first   = r_first;
        n_arena   = r_arena;
        n_used    = r_used;
        n_cur     = r_cur;
        n_guard   = r_guard;
        n_aux     = r_aux;
        n_k       = r_k;
        n_spare   = r_spare;
        n_size    = r_size;
        n_faddr   = r_faddr;
        n_ent     = r_ent;
        n_stat    = r_stat;
        n_addr    = r_addr;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_ent;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_stat  = ST_OK;
                    n_addr  = '0;
                    n_state = S_FIN;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            n_size  = CW'(req_round);
                            n_cur   = r_first;
                            n_guard = '0;
                            if (i_req_size == '0 || r_first == NIL) begin
                                n_stat = ST_NOFIT;
                            end else begin
                                ram_raddr = r_first[IW-1:0];
                                n_state   = S_AWALK;
                            end
                        end
                        REQ_FREE: begin
                            n_faddr = i_free_address;
                            n_k     = '0;
                            if (i_free_address != '0) begin
                                ram_raddr = '0;
                                n_state   = S_FSCAN;
                            end
                        end
                        REQ_INIT: begin
                            n_arena   = arena_init;
                            n_used    = '0;
                            n_inuse   = MAX_BLOCKS'(1);
                            n_first   = '0;
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = '{start: '0,
                                          len:   AW'(CW'(arena_init) - HDR),
                                          free:  1'b1,
                                          next:  NIL,
                                          prev:  NIL};
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_AWALK: begin
                if (e.free && CW'(e.len) >= r_size) begin
                    n_ent = e;
                    n_k   = '0;
                    if (CW'(e.len) >= r_size + HDR + SPLIT) begin
                        n_state = S_ASCAN;
                    end else begin
                        n_ent.free = 1'b0;
                        n_used  = AW'(CW'(r_used) + CW'(e.len) + HDR);
                        n_addr  = ADDR_W'(CW'(e.start) + HDR);
                        n_state = S_ACUR;
                    end
                end else if (e.next == NIL || g == NIL) begin
                    n_stat  = ST_NOFIT;
                    n_state = S_FIN;
                end else begin
                    n_guard   = g;
                    n_cur     = e.next;
                    ram_raddr = e.next[IW-1:0];
                end
            end

            S_ASCAN: begin
                if (!r_inuse[r_k]) begin
                    n_spare = r_k;
                    n_state = S_ASPL1;
                end else if (r_k == LASTI) begin
                    // table full: hand out the whole block
                    n_ent.free = 1'b0;
                    n_used  = AW'(CW'(r_used) + CW'(r_ent.len) + HDR);
                    n_addr  = ADDR_W'(CW'(r_ent.start) + HDR);
                    n_state = S_ACUR;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end

            S_ASPL1: begin
                ram_we    = 1'b1;
                ram_waddr = r_spare;
                ram_wdata = '{start: AW'(CW'(r_ent.start) + HDR + r_size),
                              len:   AW'(CW'(r_ent.len) - r_size - HDR),
                              free:  1'b1,
                              next:  r_ent.next,
                              prev:  r_cur};
                n_inuse[r_spare] = 1'b1;
                n_aux      = r_ent.next;
                n_ent.next = LW'(r_spare);
                n_ent.len  = AW'(r_size);
                n_ent.free = 1'b0;
                n_used     = AW'(CW'(r_used) + r_size + HDR);
                n_addr     = ADDR_W'(CW'(r_ent.start) + HDR);
                if (r_ent.next != NIL) begin
                    ram_raddr = r_ent.next[IW-1:0];
                    n_state   = S_ASPL2;
                end else begin
                    n_state = S_ACUR;
                end
            end

            S_ASPL2: begin
                ram_we         = 1'b1;
                ram_waddr      = r_aux[IW-1:0];
                ram_wdata      = e;
                ram_wdata.prev = LW'(r_spare);
                n_state        = S_ACUR;
            end

            S_ACUR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[IW-1:0];
                ram_wdata = r_ent;
                n_state   = S_FIN;
            end

            S_FSCAN: begin
                if (r_inuse[r_k] && CW'(e.start) + HDR == CW'(r_faddr)) begin
                    if (e.free) begin
                        n_stat  = ST_BADADDR;
                        n_state = S_FIN;
                    end else begin
                        n_ent      = e;
                        n_ent.free = 1'b1;
                        n_cur      = LW'(r_k);
                        n_used     = AW'(CW'(r_used) - CW'(e.len) - HDR);
                        n_state    = S_FNXT;
                    end
                end else if (r_k == LASTI) begin
                    n_stat  = ST_BADADDR;
                    n_state = S_FIN;
                end else begin
                    n_k       = r_k + IW'(1);
                    ram_raddr = r_k + IW'(1);
                end
            end

            S_FNXT: begin
                if (r_ent.next != NIL) begin
                    ram_raddr = r_ent.next[IW-1:0];
                    n_state   = S_FNW;
                end else if (r_ent.prev != NIL) begin
                    ram_raddr = r_ent.prev[IW-1:0];
                    n_state   = S_FPW;
                end else begin
                    n_state = S_FHIT;
                end
            end

            S_FNW: begin
                if (e.free) begin
                    n_ent.len  = AW'(CW'(r_ent.len) + HDR + CW'(e.len));
                    n_ent.next = e.next;
                    n_inuse[r_ent.next[IW-1:0]] = 1'b0;
                    if (e.next != NIL) begin
                        ram_raddr = e.next[IW-1:0];
                        n_state   = S_FNP;
                    end else begin
                        n_state = S_FNXT;
                    end
                end else if (r_ent.prev != NIL) begin
                    ram_raddr = r_ent.prev[IW-1:0];
                    n_state   = S_FPW;
                end else begin
                    n_state = S_FHIT;
                end
            end

            S_FNP: begin
                ram_we         = 1'b1;
                ram_waddr      = r_ent.next[IW-1:0];
                ram_wdata      = e;
                ram_wdata.prev = r_cur;
                n_state        = S_FNXT;
            end

            S_FPW: begin
                if (e.free) begin
                    // freed block disappears into its predecessor
                    ram_we         = 1'b1;
                    ram_waddr      = r_ent.prev[IW-1:0];
                    ram_wdata      = e;
                    ram_wdata.len  = AW'(CW'(e.len) + HDR + CW'(r_ent.len));
                    ram_wdata.next = r_ent.next;
                    n_inuse[r_cur[IW-1:0]] = 1'b0;
                    if (r_ent.next != NIL) begin
                        ram_raddr = r_ent.next[IW-1:0];
                        n_state   = S_FPN;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_FHIT;
                end
            end

            S_FPN: begin
                ram_we         = 1'b1;
                ram_waddr      = r_ent.next[IW-1:0];
                ram_wdata      = e;
                ram_wdata.prev = r_ent.prev;
                n_state        = S_FIN;
            end

            S_FHIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[IW-1:0];
                ram_wdata = r_ent;
                n_state   = S_FIN;
            end

            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register: holds a beat until taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pages  <= PAGES_RESET;
            r_inuse  <= '0;
            r_first  <= NIL;
            r_arena  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inuse  <= n_inuse;
            r_first  <= n_first;
            r_arena  <= n_arena;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_pages <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_guard <= n_guard;
        r_aux   <= n_aux;
        r_k     <= n_k;
        r_spare <= n_spare;
        r_size  <= n_size;
        r_faddr <= n_faddr;
        r_ent   <= n_ent;
        r_stat  <= n_stat;
        r_addr  <= n_addr;
        if (out_load) begin
            r_ostat <= r_stat;
            r_oaddr <= r_addr;
            r_otot  <= BYTES_W'(r_arena);
            r_oused <= BYTES_W'(r_used);
            r_ofree <= BYTES_W'(CW'(r_arena) - CW'(r_used));
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ostat;
    assign o_data_address = r_oaddr;
    assign o_total_bytes  = r_otot;
    assign o_used_bytes   = r_oused;
    assign o_free_bytes   = r_ofree;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_used_within_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used <= r_arena))
        else $error("used bytes exceed arena");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_first != NIL) |-> r_inuse[r_first[IW-1:0]])
        else $error("list head entry not in use");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AWALK) |-> (r_guard < NIL))
        else $error("first-fit walk overran table");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_address != '0) |-> (o_status == ST_OK))
        else $error("address returned with failing status");

endmodule
